[src/xcpd_pkg.sv]
// ----------------------------------------------------------------------------
// xcpd_pkg
// Shared types and constants of the start/length/XOR-checksum frame receiver.
// ----------------------------------------------------------------------------
package xcpd_pkg;

  localparam int unsigned MAX_PAYLOAD = 32;

  localparam logic [7:0]  START_MARKER_RST  = 8'd170;
  localparam logic [5:0]  LENGTH_LIMIT_RST  = 6'd32;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd10000;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARKER  = 2'd0,
    CFG_LENGTH_LIMIT  = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LENGTH   = 2'd1,
    ST_CHECKSUM = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_e;

  typedef struct packed {
    logic    frame_clear;
    logic    start_load;
    logic    cmd_load;
    logic    len_load;
    logic    data_load;
    logic    sil_clear;
    logic    sil_inc;
    logic    rd_clear;
    logic    rd_next;
    logic    out_load;
    logic    out_end;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    logic start_hit;
    logic len_over;
    logic len_zero;
    logic data_done;
    logic xor_ok;
    logic timeout_hit;
    logic held_zero;
    logic rd_last;
    logic out_free;
  } stat_t;

endpackage

[src/xcpd_ctrl.sv]
// ----------------------------------------------------------------------------
// xcpd_ctrl
// Frame sequencer: hunts for the start byte, walks the header, payload and
// checksum phases, and drives the buffer readout after a good frame.
// ----------------------------------------------------------------------------
module xcpd_ctrl
  import xcpd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  operation_i,
  input  stat_t stat_i,
  output logic  in_stall_o,
  output cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_HUNT     = 8'b0000_0001,
    S_CMD      = 8'b0000_0010,
    S_LEN      = 8'b0000_0100,
    S_DATA     = 8'b0000_1000,
    S_CHECK    = 8'b0001_0000,
    S_RD_ADDR  = 8'b0010_0000,
    S_RD_OUT   = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   taking;
  logic   accept;

  assign taking = (state_q == S_HUNT) || (state_q == S_CMD) || (state_q == S_LEN) ||
                  (state_q == S_DATA) || (state_q == S_CHECK);
  assign in_stall_o = !(taking && stat_i.out_free);
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_status = ST_OK;
    unique case (state_q)
      S_HUNT: begin
        if (accept && operation_i == OP_BYTE && stat_i.start_hit) begin
          cmd_o.start_load = 1'b1;
          state_d = S_CMD;
        end
      end
      S_CMD, S_LEN, S_DATA, S_CHECK: begin
        if (accept && operation_i == OP_TICK) begin
          cmd_o.sil_inc = 1'b1;
          if (stat_i.timeout_hit) begin
            cmd_o.out_load    = 1'b1;
            cmd_o.out_end     = 1'b1;
            cmd_o.out_status  = ST_TIMEOUT;
            cmd_o.frame_clear = 1'b1;
            state_d = S_HUNT;
          end
        end else if (accept) begin
          cmd_o.sil_clear = 1'b1;
          if (state_q == S_CMD) begin
            cmd_o.cmd_load = 1'b1;
            state_d = S_LEN;
          end else if (state_q == S_LEN) begin
            cmd_o.len_load = 1'b1;
            if (stat_i.len_over) begin
              cmd_o.out_load    = 1'b1;
              cmd_o.out_end     = 1'b1;
              cmd_o.out_status  = ST_LENGTH;
              cmd_o.frame_clear = 1'b1;
              state_d = S_HUNT;
            end else if (stat_i.len_zero) begin
              state_d = S_CHECK;
            end else begin
              state_d = S_DATA;
            end
          end else if (state_q == S_DATA) begin
            cmd_o.data_load = 1'b1;
            if (stat_i.data_done) begin
              state_d = S_CHECK;
            end
          end else begin
            if (!stat_i.xor_ok) begin
              cmd_o.out_load    = 1'b1;
              cmd_o.out_end     = 1'b1;
              cmd_o.out_status  = ST_CHECKSUM;
              cmd_o.frame_clear = 1'b1;
              state_d = S_HUNT;
            end else begin
              cmd_o.rd_clear = 1'b1;
              state_d = stat_i.held_zero ? S_FINISH : S_RD_ADDR;
            end
          end
        end
      end
      S_RD_ADDR: begin
        state_d = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.rd_next  = 1'b1;
          state_d = stat_i.rd_last ? S_FINISH : S_RD_ADDR;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_end     = 1'b1;
          cmd_o.out_status  = ST_OK;
          cmd_o.frame_clear = 1'b1;
          state_d = S_HUNT;
        end
      end
      default: begin
        state_d = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/xcpd_datapath.sv]
// ----------------------------------------------------------------------------
// xcpd_datapath
// Configuration registers, frame header and checksum registers, silence
// counter, payload buffer and the result output register.
// ----------------------------------------------------------------------------
module xcpd_datapath
  import xcpd_pkg::*;
#(
  parameter int unsigned MaxPayload = MAX_PAYLOAD
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_write_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]            rx_byte_i,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic                  kind_o,
  output logic [1:0]            status_o,
  output logic [7:0]            command_code_o,
  output logic [7:0]            frame_length_o,
  output logic [4:0]            byte_index_o,
  output logic [7:0]            payload_byte_o,
  output logic                  last_o
);

  localparam int unsigned AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int unsigned CntW  = $clog2(MaxPayload + 1);
  localparam logic [7:0]  MaxLen = 8'(MaxPayload);

  logic [7:0]      start_marker_q;
  logic [5:0]      length_limit_q;
  logic [15:0]     timeout_ticks_q;
  logic [7:0]      held_command_q;
  logic [7:0]      held_length_q;
  logic [CntW-1:0] payload_count_q;
  logic [7:0]      running_xor_q;
  logic [15:0]     silence_q;
  logic [AddrW-1:0] rd_idx_q;
  logic [7:0]      rdata_q;
  logic [7:0]      mem [MaxPayload];

  logic            out_valid_q;
  logic            out_kind_q;
  status_e         out_status_q;
  logic [7:0]      out_command_q;
  logic [7:0]      out_length_q;
  logic [4:0]      out_index_q;
  logic [7:0]      out_payload_q;

  logic [7:0]      limit_eff;
  logic [15:0]     sil_next;
  logic [15:0]     sil_limit;
  cfg_idx_e        cfg_idx;

  assign cfg_idx   = cfg_idx_e'(cfg_index_i);
  assign limit_eff = ({2'b00, length_limit_q} > MaxLen) ? MaxLen : {2'b00, length_limit_q};
  assign sil_next  = (silence_q == 16'hFFFF) ? silence_q : silence_q + 16'd1;
  assign sil_limit = (timeout_ticks_q == 16'd0) ? 16'd1 : timeout_ticks_q;

  assign stat_o.start_hit   = (rx_byte_i == start_marker_q);
  assign stat_o.len_over    = (rx_byte_i > limit_eff);
  assign stat_o.len_zero    = (rx_byte_i == 8'd0);
  assign stat_o.data_done   = ((8'(payload_count_q) + 8'd1) >= held_length_q);
  assign stat_o.xor_ok      = (rx_byte_i == running_xor_q);
  assign stat_o.timeout_hit = (sil_next >= sil_limit);
  assign stat_o.held_zero   = (held_length_q == 8'd0);
  assign stat_o.rd_last     = ((8'(rd_idx_q) + 8'd1) == held_length_q);
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q  <= START_MARKER_RST;
      length_limit_q  <= LENGTH_LIMIT_RST;
      timeout_ticks_q <= TIMEOUT_TICKS_RST;
    end else if (cfg_write_i) begin
      unique case (cfg_idx)
        CFG_START_MARKER:  start_marker_q  <= cfg_data_i[7:0];
        CFG_LENGTH_LIMIT:  length_limit_q  <= cfg_data_i[5:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_command_q  <= '0;
      held_length_q   <= '0;
      payload_count_q <= '0;
      running_xor_q   <= '0;
      silence_q       <= '0;
      rd_idx_q        <= '0;
    end else begin
      if (cmd_i.frame_clear) begin
        held_command_q  <= '0;
        held_length_q   <= '0;
        payload_count_q <= '0;
        running_xor_q   <= '0;
        silence_q       <= '0;
      end else begin
        if (cmd_i.start_load) begin
          held_command_q  <= '0;
          held_length_q   <= '0;
          payload_count_q <= '0;
          running_xor_q   <= rx_byte_i;
          silence_q       <= '0;
        end
        if (cmd_i.cmd_load) begin
          held_command_q <= rx_byte_i;
          running_xor_q  <= running_xor_q ^ rx_byte_i;
        end
        if (cmd_i.len_load) begin
          held_length_q   <= rx_byte_i;
          running_xor_q   <= running_xor_q ^ rx_byte_i;
          payload_count_q <= '0;
        end
        if (cmd_i.data_load) begin
          payload_count_q <= payload_count_q + CntW'(1);
          running_xor_q   <= running_xor_q ^ rx_byte_i;
        end
        if (cmd_i.sil_clear) begin
          silence_q <= '0;
        end else if (cmd_i.sil_inc) begin
          silence_q <= sil_next;
        end
      end
      if (cmd_i.rd_clear) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_next) begin
        rd_idx_q <= rd_idx_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.data_load) begin
      mem[payload_count_q[AddrW-1:0]] <= rx_byte_i;
    end
    rdata_q <= mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q    <= cmd_i.out_end;
      out_status_q  <= cmd_i.out_end ? cmd_i.out_status : ST_OK;
      out_command_q <= held_command_q;
      out_length_q  <= cmd_i.len_load ? rx_byte_i : held_length_q;
      out_index_q   <= cmd_i.out_end ? 5'd0 : 5'(rd_idx_q);
      out_payload_q <= cmd_i.out_end ? 8'd0 : rdata_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign status_o       = out_status_q;
  assign command_code_o = out_command_q;
  assign frame_length_o = out_length_q;
  assign byte_index_o   = out_index_q;
  assign payload_byte_o = out_payload_q;
  assign last_o         = out_kind_q;

endmodule

[src/xor_checked_packet_deframer.sv]
// ----------------------------------------------------------------------------
// xor_checked_packet_deframer
// Start/length/XOR-checksum frame receiver with payload buffer and readout.
// ----------------------------------------------------------------------------
// Received bytes and time ticks enter one item per clock while a frame is
// being hunted for or received, unless the result register is full and
// stalled downstream; the input also stalls during readout. After a good
// checksum the buffered payload is read out through the registered buffer
// read port, each byte through an address state and an output state, then
// the ok end result is sent. Error results (length too large, checksum
// mismatch, timeout) are registered and come out in the cycle after the
// item that causes them. Configuration writes are always taken.
module xor_checked_packet_deframer
  import xcpd_pkg::*;
#(
  parameter int unsigned MaxPayload = MAX_PAYLOAD
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  kind_o,
  output logic [1:0]            status_o,
  output logic [7:0]            command_code_o,
  output logic [7:0]            frame_length_o,
  output logic [4:0]            byte_index_o,
  output logic [7:0]            payload_byte_o,
  output logic                  last_o
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  xcpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  xcpd_datapath #(
    .MaxPayload (MaxPayload)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_write_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .status_o       (status_o),
    .command_code_o (command_code_o),
    .frame_length_o (frame_length_o),
    .byte_index_o   (byte_index_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o)
  );

endmodule
